### hdl/wpwrb_pkg.sv
// Package: constants, types and state codes of the window pixel write register block.
package wpwrb_pkg;

    localparam int MEM_WORDS        = 524288;
    localparam int FRAME_BASE_BYTES = 131072;
    localparam int LINE_STRIDE      = 321;

    localparam int ADDR_W    = 19;
    localparam int DATA_W    = 32;
    localparam int COORD_W   = 16;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int STRIDE_W  = $clog2(LINE_STRIDE + 1);
    localparam int SUM_W     = COORD_W + 1;
    localparam int PROD_W    = SUM_W + STRIDE_W;
    localparam int HALF_W    = 32;
    localparam int FRAME_HALF = FRAME_BASE_BYTES / 2;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int S_TDATA_W = 88;

    localparam logic [ADDR_W-1:0]  ID_WORD       = ADDR_W'('h4c / 4);
    localparam logic [DATA_W-1:0]  ID_VALUE      = 32'h0014_5000;
    localparam logic [ADDR_W-1:0]  CMD_CURSOR_RST = ADDR_W'('h300 / 4);
    localparam logic [ADDR_W-1:0]  CMD_WIN_SIZE  = ADDR_W'('h304 / 4);
    localparam logic [ADDR_W-1:0]  CMD_WIN_ORG   = ADDR_W'('h308 / 4);
    localparam logic [ADDR_W-1:0]  PUSH_FIRST    = ADDR_W'('h200 / 4);
    localparam logic [ADDR_W-1:0]  PUSH_END      = ADDR_W'('h280 / 4);
    localparam logic [COORD_W-1:0] COORD_MAX     = 16'hFFFF;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_CURSOR,
        CMD_SIZE,
        CMD_ORIGIN
    } t_cmd;

    typedef struct packed {
        t_op               op;
        t_cmd              cmd;
        logic              is_id;
        logic              in_mem;
        logic              is_push;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] mask;
    } t_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_FETCH,
        S_RDATA,
        S_MERGE,
        S_PMUL,
        S_PADDR,
        S_PWRITE
    } t_state;

endpackage

### hdl/wpwrb_ram.sv
// Generic single-port RAM with registered read.
module wpwrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/wpwrb_front.sv
// Front stage: accept bus accesses, classify them and hand them to the queue.
module wpwrb_front import wpwrb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clearing,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output t_item                o_q_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;
    logic [ADDR_W-1:0] addr;

    assign o_s_tready = !i_clearing && (!r_valid || i_q_ready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign addr       = i_s_tdata[ADDR_W-1:0];

    always_comb begin
        n_item.op      = i_s_tuser ? OP_WRITE : OP_READ;
        n_item.addr    = addr;
        n_item.data    = i_s_tdata[ADDR_W+DATA_W-1:ADDR_W];
        n_item.mask    = i_s_tdata[ADDR_W+2*DATA_W-1:ADDR_W+DATA_W];
        n_item.is_id   = (addr == ID_WORD);
        n_item.in_mem  = (32'(addr) < 32'(MEM_WORDS));
        n_item.is_push = (addr >= PUSH_FIRST) && (addr < PUSH_END);
        priority if (addr == CMD_CURSOR_RST) begin
            n_item.cmd = CMD_CURSOR;
        end else if (addr == CMD_WIN_SIZE) begin
            n_item.cmd = CMD_SIZE;
        end else if (addr == CMD_WIN_ORG) begin
            n_item.cmd = CMD_ORIGIN;
        end else begin
            n_item.cmd = CMD_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_q_valid = r_valid;
    assign o_q_item  = r_item;

endmodule

### hdl/wpwrb_queue.sv
// Two-entry queue between the front stage and the executing back end.
module wpwrb_queue import wpwrb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;
    logic                push;
    logic                pop;

    assign o_ready = (r_count != (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### hdl/wpwrb_back.sv
// Back end: memory clear, word merge, window commands and pixel stores.
module wpwrb_back import wpwrb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    input  t_item             i_q_item,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,
    output logic              o_clearing
);

    localparam logic [MEM_AW-1:0]   CLR_LAST  = MEM_AW'(MEM_WORDS - 1);
    localparam logic [STRIDE_W-1:0] STRIDE_C  = STRIDE_W'(LINE_STRIDE);

    t_state r_state, n_state;
    t_item  r_item, n_item;
    logic [MEM_AW-1:0]  r_clr, n_clr;
    logic [COORD_W-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [COORD_W-1:0] r_width, n_width, r_height, n_height;
    logic [COORD_W-1:0] r_ox, n_ox, r_oy, n_oy;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic               r_inside, n_inside;
    logic               r_pw_ok, n_pw_ok;
    logic               r_hsel, n_hsel;
    logic               r_pix, n_pix;
    logic [MEM_AW-1:0]  r_paddr, n_paddr;
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_out_data, n_out_data;

    logic               ram_we, ram_re;
    logic [MEM_AW-1:0]  ram_addr;
    logic [DATA_W-1:0]  ram_wdata, ram_rdata;
    logic [31:0]        item_addr32;
    logic [SUM_W-1:0]   row_sum;
    logic [HALF_W-1:0]  half;
    logic [HALF_W-2:0]  pword;
    logic [COORD_W-1:0] pixel;
    logic [COORD_W-1:0] cx_new;

    wpwrb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_ox        <= '0;
            r_oy        <= '0;
            r_pix       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_width     <= n_width;
            r_height    <= n_height;
            r_ox        <= n_ox;
            r_oy        <= n_oy;
            r_pix       <= n_pix;
            r_out_valid <= n_out_valid;
        end
        r_item     <= n_item;
        r_prod     <= n_prod;
        r_inside   <= n_inside;
        r_pw_ok    <= n_pw_ok;
        r_hsel     <= n_hsel;
        r_paddr    <= n_paddr;
        r_out_data <= n_out_data;
    end

    assign item_addr32 = 32'(r_item.addr);
    assign row_sum     = SUM_W'(r_oy) + SUM_W'(r_cy);
    assign half        = HALF_W'(FRAME_HALF) + HALF_W'(r_prod) + HALF_W'(r_ox) + HALF_W'(r_cx);
    assign pword       = half[HALF_W-1:1];
    assign pixel       = r_pix ? r_item.data[31:16] : r_item.data[15:0];
    assign cx_new      = r_inside ? r_cx + 1'b1 : r_cx;

    always_comb begin
        logic [31:0] q_addr32;
        q_addr32    = 32'(i_q_item.addr);
        n_state     = r_state;
        n_item      = r_item;
        n_clr       = r_clr;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_width     = r_width;
        n_height    = r_height;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_prod      = r_prod;
        n_inside    = r_inside;
        n_pw_ok     = r_pw_ok;
        n_hsel      = r_hsel;
        n_pix       = r_pix;
        n_paddr     = r_paddr;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_m_tready;
        o_q_ready   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = '0;
        ram_wdata   = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_q_ready = 1'b1;
                ram_addr  = q_addr32[MEM_AW-1:0];
                if (i_q_valid) begin
                    ram_re  = 1'b1;
                    n_item  = i_q_item;
                    n_state = (i_q_item.op == OP_READ) ? S_RDATA : S_MERGE;
                end
            end
            S_RDATA: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    if (r_item.is_id) begin
                        n_out_data = ID_VALUE;
                    end else if (r_item.in_mem) begin
                        n_out_data = ram_rdata;
                    end else begin
                        n_out_data = '0;
                    end
                    n_state = S_FETCH;
                end
            end
            S_MERGE: begin
                ram_we    = r_item.in_mem;
                ram_addr  = item_addr32[MEM_AW-1:0];
                ram_wdata = (ram_rdata & ~r_item.mask) | (r_item.data & r_item.mask);
                unique case (r_item.cmd)
                    CMD_CURSOR: begin
                        n_cx = '0;
                        n_cy = '0;
                    end
                    CMD_SIZE: begin
                        n_width  = r_item.data[15:0];
                        n_height = r_item.data[31:16];
                        if (r_item.data[0]) begin
                            n_ox = r_ox + 1'b1;
                        end
                    end
                    CMD_ORIGIN: begin
                        n_ox = {r_item.data[15:1], 1'b0};
                        n_oy = r_item.data[31:16];
                    end
                    CMD_NONE: begin
                    end
                    default: begin
                    end
                endcase
                n_pix   = 1'b0;
                n_state = r_item.is_push ? S_PMUL : S_FETCH;
            end
            S_PMUL: begin
                n_prod   = PROD_W'(row_sum * STRIDE_C);
                n_inside = (r_cx < r_width) && (r_cy < r_height);
                n_state  = S_PADDR;
            end
            S_PADDR: begin
                n_pw_ok  = r_inside && (pword < (HALF_W-1)'(MEM_WORDS));
                n_hsel   = half[0];
                n_paddr  = pword[MEM_AW-1:0];
                ram_re   = 1'b1;
                ram_addr = pword[MEM_AW-1:0];
                n_state  = S_PWRITE;
            end
            S_PWRITE: begin
                ram_we    = r_pw_ok;
                ram_addr  = r_paddr;
                ram_wdata = r_hsel ? {pixel, ram_rdata[15:0]} : {ram_rdata[31:16], pixel};
                if (!r_pix) begin
                    n_cx    = cx_new;
                    n_pix   = 1'b1;
                    n_state = S_PMUL;
                end else begin
                    if (cx_new >= r_width) begin
                        n_cx = '0;
                        if (r_cy != COORD_MAX) begin
                            n_cy = r_cy + 1'b1;
                        end
                    end else begin
                        n_cx = cx_new;
                    end
                    n_state = S_FETCH;
                end
            end
            default: begin
                n_state = S_FETCH;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_clearing = (r_state == S_CLEAR);

    a_read_goes_to_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && o_q_ready && i_q_item.op == OP_READ) |=> (r_state == S_RDATA))
        else $error("read item did not enter the read-data state");

    a_pixel_store_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PWRITE && ram_we) |-> r_inside)
        else $error("pixel stored outside the window");

    a_cursor_x_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_state != S_PWRITE && r_state != S_MERGE) |=> $stable(r_cx))
        else $error("cursor x changed outside merge or pixel store");

    a_out_from_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RDATA))
        else $error("result raised outside the read-data state");

endmodule

### hdl/window_pixel_write_register_block_top.sv
// Top level: 32-bit word memory with window commands and pixel-push writes.
// A read item passes the front-stage register, the queue, the fetch and read-data states
// and the output register before o_m_tvalid rises. The back end takes a read through fetch
// and read-data (held there while the output is full), a plain write through fetch and merge,
// a pixel push through fetch, merge, then per pixel a multiply, an address and a read-modify-write state.
// The single RAM port and the pixel sequencer set this sequence. Reset: synchronous, active low;
// the memory is then cleared one word a cycle, all MEM_WORDS (524288) words, during which o_s_tready stays low.
module window_pixel_write_register_block_top import wpwrb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // word_address[18:0], write_data[50:19],
                                             // write_mask[82:51], zeros above
    input  logic                 i_s_tuser,  // kind
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [DATA_W-1:0]    o_m_tdata   // read_data[31:0]
);

    logic  clearing;
    logic  fq_valid, fq_ready;
    t_item fq_item;
    logic  qb_valid, qb_ready;
    t_item qb_item;

    wpwrb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clearing (clearing),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (fq_valid),
        .i_q_ready  (fq_ready),
        .o_q_item   (fq_item)
    );

    wpwrb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_item  (fq_item),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_item  (qb_item)
    );

    wpwrb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (qb_valid),
        .o_q_ready  (qb_ready),
        .i_q_item   (qb_item),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_clearing (clearing)
    );

endmodule

### test/window_pixel_write_register_block_chk.sv
// Checker: watches both streams, predicts read data of the window pixel block, compares.
module window_pixel_write_register_block_chk import wpwrb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // word_address[18:0], write_data[50:19],
                                             // write_mask[82:51], zeros above
    input  logic                 i_s_tuser,  // kind
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [DATA_W-1:0]    i_m_tdata,  // read_data[31:0]
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_read_count,
    output int                   o_push_count,
    output int                   o_pixel_count,
    output int                   o_offmem_count
);

    logic [DATA_W-1:0]  word_mem [int unsigned];
    logic [DATA_W-1:0]  read_results [$];
    logic [COORD_W-1:0] cur_x = '0;
    logic [COORD_W-1:0] cur_y = '0;
    logic [COORD_W-1:0] win_w = '0;
    logic [COORD_W-1:0] win_h = '0;
    logic [COORD_W-1:0] org_x = '0;
    logic [COORD_W-1:0] org_y = '0;
    int fails   = 0;
    int reads   = 0;
    int pushes  = 0;
    int pixels  = 0;
    int offmem  = 0;

    function automatic logic [DATA_W-1:0] mem_word(input int unsigned addr);
        if (word_mem.exists(addr)) return word_mem[addr];
        return '0;
    endfunction

    task automatic store_pixel(input logic [COORD_W-1:0] pix);
        longint unsigned half;
        longint unsigned widx;
        logic [DATA_W-1:0] old;
        if (cur_x >= win_w || cur_y >= win_h) return;
        half = 64'(FRAME_HALF) + (64'(org_y) + 64'(cur_y)) * 64'(LINE_STRIDE)
             + 64'(org_x) + 64'(cur_x);
        widx = half >> 1;
        if (widx < 64'(MEM_WORDS)) begin
            old = mem_word(32'(widx));
            if (half[0]) begin
                word_mem[32'(widx)] = {pix, old[15:0]};
            end else begin
                word_mem[32'(widx)] = {old[31:16], pix};
            end
            pixels++;
        end else begin
            offmem++;
        end
        cur_x = cur_x + 1'b1;
    endtask

    task automatic apply_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data,
                               input logic [DATA_W-1:0] mask);
        if (int'(addr) < MEM_WORDS) word_mem[addr] = (mem_word(addr) & ~mask) | (data & mask);
        if (addr == CMD_CURSOR_RST) begin
            cur_x = '0;
            cur_y = '0;
        end else if (addr == CMD_WIN_SIZE) begin
            win_w = data[COORD_W-1:0];
            win_h = data[DATA_W-1:COORD_W];
            if (win_w[0]) org_x = org_x + 1'b1;
        end else if (addr == CMD_WIN_ORG) begin
            org_x = {data[COORD_W-1:1], 1'b0};
            org_y = data[DATA_W-1:COORD_W];
        end
        if (addr >= PUSH_FIRST && addr < PUSH_END) begin
            pushes++;
            store_pixel(data[COORD_W-1:0]);
            store_pixel(data[DATA_W-1:COORD_W]);
            if (cur_x >= win_w) begin
                cur_x = '0;
                if (cur_y != COORD_MAX) cur_y = cur_y + 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic [DATA_W-1:0] want;
        logic [ADDR_W-1:0] addr;
        t_op               op;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (read_results.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("%0t: read_data %h with no read pending",
                                              $time, i_m_tdata);
                end else begin
                    want = read_results.pop_front();
                    if (i_m_tdata !== want) begin
                        fails++;
                        if (fails <= 10) $display("%0t: read_data expected %h, got %h",
                                                  $time, want, i_m_tdata);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                op   = t_op'(i_s_tuser);
                addr = i_s_tdata[ADDR_W-1:0];
                if (op == OP_READ) begin
                    want = (int'(addr) < MEM_WORDS) ? mem_word(addr) : '0;
                    if (addr == ID_WORD) want = ID_VALUE;
                    read_results.push_back(want);
                    reads++;
                end else begin
                    apply_write(addr, i_s_tdata[ADDR_W +: DATA_W],
                                i_s_tdata[ADDR_W+DATA_W +: DATA_W]);
                end
            end
        end
        o_fail_count   <= fails;
        o_pending      <= read_results.size();
        o_read_count   <= reads;
        o_push_count   <= pushes;
        o_pixel_count  <= pixels;
        o_offmem_count <= offmem;
    end

endmodule

### test/window_pixel_write_register_block_top_tb.sv
// Testbench top: bus access stimulus for the window pixel write block and the verdict.
module window_pixel_write_register_block_top_tb;
    import wpwrb_pkg::*;

    localparam int RANDOM_ITEMS  = 1450;
    localparam int ZERO_W_PUSHES = 200;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // word_address[18:0], write_data[50:19],
                                          // write_mask[82:51], zeros above
    logic                 s_tuser  = 1'b0;  // kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DATA_W-1:0]    m_tdata;  // read_data[31:0]
    logic                 no_stall = 1'b0;
    int fail_count;
    int pending;
    int read_count;
    int push_count;
    int pixel_count;
    int offmem_count;
    int sent = 0;
    logic [ADDR_W-1:0] touched [$];

    window_pixel_write_register_block_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    window_pixel_write_register_block_chk i_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_read_count   (read_count),
        .o_push_count   (push_count),
        .o_pixel_count  (pixel_count),
        .o_offmem_count (offmem_count)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) m_tready <= no_stall || ($urandom_range(99) >= 24);

    task automatic put_access(input t_op op, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data = '0,
                              input logic [DATA_W-1:0] mask = '0);
        if (!no_stall) begin
            while ($urandom_range(99) < 24) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({mask, data, addr});
        do @(posedge clk); while (!s_tready);
        sent++;
        if (op == OP_WRITE) begin
            touched.push_back(addr);
            if (touched.size() > 64) void'(touched.pop_front());
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic read_window(input int ox, input int oy, input int w, input int rows);
        longint unsigned first;
        for (int r = 0; r < rows; r++) begin
            first = (64'(FRAME_HALF) + 64'(oy + r) * 64'(LINE_STRIDE) + 64'(ox)) >> 1;
            for (int c = 0; c <= w / 2 + 1; c++) begin
                if (first + c < 64'(MEM_WORDS)) put_access(OP_READ, ADDR_W'(first + c));
            end
        end
    endtask

    initial begin
        int start;
        int ox;
        int oy;
        int w;
        int h;
        int rows;
        int n;
        logic [ADDR_W-1:0] addr;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        put_access(OP_READ, ID_WORD);
        put_access(OP_READ, '0);
        put_access(OP_READ, '1);
        put_access(OP_WRITE, ID_WORD, '1, '1);
        put_access(OP_READ, ID_WORD);
        put_access(OP_WRITE, '1, '1, 32'h0000_FFFF);
        put_access(OP_WRITE, '1, 32'hA5A5_5A5A, 32'hFFFF_0000);
        put_access(OP_READ, '1);
        // round the odd origin down, then bump it back with an odd width
        put_access(OP_WRITE, CMD_WIN_ORG, {16'd2, 16'd5}, '0);
        put_access(OP_WRITE, CMD_WIN_SIZE, {16'd2, 16'd3}, '1);
        put_access(OP_WRITE, CMD_CURSOR_RST, '1, '1);
        put_access(OP_WRITE, PUSH_FIRST, 32'h1111_2222, '1);
        put_access(OP_WRITE, PUSH_END - 1'b1, 32'h3333_4444, '0);
        put_access(OP_WRITE, PUSH_FIRST + 1'b1, 32'hFFFF_0000, 32'h0F0F_0F0F);
        read_window(5, 2, 3, 2);
        put_access(OP_READ, CMD_WIN_ORG);
        // zero height: push stores nothing
        put_access(OP_WRITE, CMD_WIN_SIZE, {16'd0, 16'd4}, '0);
        put_access(OP_WRITE, PUSH_FIRST, '1, '0);
        // window far past the memory end: drop pixels
        put_access(OP_WRITE, CMD_WIN_ORG, {16'hFFFF, 16'hFFFE}, '1);
        put_access(OP_WRITE, CMD_WIN_SIZE, {16'd1, 16'd2}, '1);
        put_access(OP_WRITE, CMD_CURSOR_RST, '0, '0);
        put_access(OP_WRITE, PUSH_FIRST + 5'd5, 32'hBEEF_CAFE, '1);
        wait_drained();

        // zero width: every push only advances the row
        no_stall <= 1'b1;
        put_access(OP_WRITE, CMD_WIN_ORG, '0, '0);
        put_access(OP_WRITE, CMD_WIN_SIZE, {16'hFFFF, 16'd0}, '0);
        put_access(OP_WRITE, CMD_CURSOR_RST, '0, '0);
        repeat (ZERO_W_PUSHES) begin
            put_access(OP_WRITE, PUSH_FIRST + ADDR_W'($urandom_range(31)), $urandom, $urandom);
        end
        put_access(OP_WRITE, CMD_WIN_SIZE, {16'hFFFF, 16'd2}, '0);
        put_access(OP_WRITE, PUSH_FIRST, 32'h5A5A_A5A5, '0);
        put_access(OP_READ, ADDR_W'(FRAME_HALF / 2));
        no_stall <= 1'b0;
        wait_drained();

        start = sent;
        while (sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    ox = ($urandom_range(9) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(320);
                    oy = ($urandom_range(7) == 0) ? $urandom_range(16'hFFFF, 3000)
                                                  : $urandom_range(200);
                    w  = $urandom_range(9);
                    h  = ($urandom_range(9) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(5);
                    rows = (h < 6) ? h : 6;
                    put_access(OP_WRITE, CMD_WIN_ORG, {16'(oy), 16'(ox)}, $urandom);
                    ox = ox & 'hFFFE;
                    put_access(OP_WRITE, CMD_WIN_SIZE, {16'(h), 16'(w)}, $urandom);
                    if (w % 2 == 1) ox = (ox + 1) & 'hFFFF;
                    if ($urandom_range(4) != 0) begin
                        put_access(OP_WRITE, CMD_CURSOR_RST, $urandom, $urandom);
                    end
                    n = $urandom_range((w / 2 + 1) * rows + 2, 1);
                    repeat (n) begin
                        put_access(OP_WRITE, PUSH_FIRST + ADDR_W'($urandom_range(31)),
                                   $urandom, $urandom);
                    end
                    read_window(ox, oy, w, rows);
                end
                6: begin
                    addr = ADDR_W'($urandom);
                    put_access(OP_WRITE, addr, $urandom, $urandom);
                    put_access(OP_READ, addr);
                end
                7: begin
                    if (touched.size() != 0 && $urandom_range(1) == 0) begin
                        put_access(OP_READ, touched[$urandom_range(touched.size() - 1)]);
                    end else begin
                        put_access(OP_READ, ADDR_W'($urandom), $urandom, $urandom);
                    end
                end
                8: begin
                    put_access(OP_READ, ID_WORD);
                    put_access(OP_READ, CMD_CURSOR_RST);
                    put_access(OP_READ, CMD_WIN_SIZE);
                    put_access(OP_READ, CMD_WIN_ORG);
                    put_access(OP_READ, PUSH_FIRST + ADDR_W'($urandom_range(31)));
                end
                default: begin
                    case ($urandom_range(3))
                        0: put_access(OP_WRITE, CMD_WIN_SIZE, $urandom, $urandom);
                        1: put_access(OP_WRITE, CMD_WIN_ORG, $urandom, $urandom);
                        2: put_access(OP_WRITE, ID_WORD, $urandom, $urandom);
                        default: put_access(OP_WRITE, CMD_CURSOR_RST, $urandom, $urandom);
                    endcase
                    repeat ($urandom_range(4)) begin
                        put_access(OP_WRITE, PUSH_FIRST + ADDR_W'($urandom_range(31)),
                                   $urandom, $urandom);
                    end
                end
            endcase
            if ($urandom_range(19) == 0) wait_drained();
            no_stall <= ($urandom_range(9) == 0);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("summary: %0d accesses, %0d reads checked, %0d pixel-push writes",
                 sent, read_count, push_count);
        $display("summary: %0d pixels stored, %0d pixels dropped past the memory end",
                 pixel_count, offmem_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
hdl/wpwrb_pkg.sv
hdl/wpwrb_ram.sv
hdl/wpwrb_front.sv
hdl/wpwrb_queue.sv
hdl/wpwrb_back.sv
hdl/window_pixel_write_register_block_top.sv
test/window_pixel_write_register_block_chk.sv
test/window_pixel_write_register_block_top_tb.sv
